// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the object file record parser
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// overlapping implication checked on every rising clock edge out of reset
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// non-overlapping implication, checked on the rising clock edge
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/ofrp_pkg.sv
// ----------------------------------------------------------------------------
// ofrp_pkg
// Types and constants shared by the object file record parser modules
// ----------------------------------------------------------------------------
`default_nettype none

package ofrp_pkg;

    // record header words
    localparam logic [15:0] HDR_CODE   = 16'hCADE;
    localparam logic [15:0] HDR_DATA   = 16'hDADA;
    localparam logic [15:0] HDR_SYMBOL = 16'hC3B7;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    // parse phase of the front end
    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_ADDRESS = 3'd1,
        PH_COUNT   = 3'd2,
        PH_WORDS   = 3'd3,
        PH_LABEL   = 3'd4
    } t_phase;

    // record kind codes, also used as the result kind
    typedef enum logic [1:0] {
        KIND_CODE   = 2'd0,
        KIND_DATA   = 2'd1,
        KIND_SYMBOL = 2'd2,
        KIND_EMPTY  = 2'd3
    } t_kind;

    // operation carried from front to back
    typedef enum logic {
        OP_SET_ADDR = 1'b0,
        OP_EMIT     = 1'b1
    } t_op;

    // one queued operation
    typedef struct packed {
        t_op         op;
        t_kind       kind;
        logic [15:0] value;
        logic        last;
    } t_token;

endpackage

`default_nettype wire

// File: src/ofrp_if.sv
// ----------------------------------------------------------------------------
// ofrp_if
// Valid/ready channel interfaces for file bytes and parsed records
// ----------------------------------------------------------------------------
`default_nettype none

// byte stream channel
interface ofrp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] file_byte;

    modport source (output valid, output file_byte, input ready);
    modport sink   (input valid, input file_byte, output ready);
endinterface

// parsed record channel
interface ofrp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  record_kind;
    logic [15:0] target_address;
    logic [15:0] payload_value;
    logic        last_of_label;

    modport source (output valid, output record_kind, output target_address,
                    output payload_value, output last_of_label, input ready);
    modport sink   (input valid, input record_kind, input target_address,
                    input payload_value, input last_of_label, output ready);
endinterface

`default_nettype wire

// File: src/ofrp_front.sv
// ----------------------------------------------------------------------------
// ofrp_front
// Pairs bytes into big-endian words, tracks the record phase and turns each
// byte into at most one operation for the back end
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ofrp_front import ofrp_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ofrp_in_if.sink     i_byte,
    output t_token      o_token,
    output logic        o_token_valid,
    input  wire logic   i_token_ready
);

    t_phase      r_phase,   n_phase;
    logic        r_pending, n_pending;
    logic [7:0]  r_upper,   n_upper;
    t_kind       r_section, n_section;
    logic [15:0] r_count,   n_count;

    logic        w_accept;
    logic [15:0] w_word;

    // a byte is taken whenever the queue has room
    assign i_byte.ready = i_token_ready;
    assign w_accept     = i_byte.valid && i_token_ready;
    assign w_word       = {r_upper, i_byte.file_byte};

    // next state
    always_comb begin
        n_phase   = r_phase;
        n_pending = r_pending;
        n_upper   = r_upper;
        n_section = r_section;
        n_count   = r_count;
        if (w_accept) begin
            if (r_phase == PH_LABEL) begin
                n_count = r_count - 16'd1;
                if (r_count == 16'd1) begin
                    n_phase = PH_HEADER;
                end
            end else if (!r_pending) begin
                n_upper   = i_byte.file_byte;
                n_pending = 1'b1;
            end else begin
                n_pending = 1'b0;
                case (r_phase)
                    PH_HEADER: begin
                        if (w_word inside {HDR_CODE, HDR_DATA, HDR_SYMBOL}) begin
                            n_phase = PH_ADDRESS;
                        end
                        if (w_word == HDR_CODE) begin
                            n_section = KIND_CODE;
                        end else if (w_word == HDR_DATA) begin
                            n_section = KIND_DATA;
                        end else if (w_word == HDR_SYMBOL) begin
                            n_section = KIND_SYMBOL;
                        end
                    end
                    PH_ADDRESS: begin
                        n_phase = PH_COUNT;
                    end
                    PH_COUNT: begin
                        n_count = w_word;
                        if (w_word == 16'd0) begin
                            n_phase = PH_HEADER;
                        end else if (r_section == KIND_SYMBOL) begin
                            n_phase = PH_LABEL;
                        end else begin
                            n_phase = PH_WORDS;
                        end
                    end
                    PH_WORDS: begin
                        n_count = r_count - 16'd1;
                        if (r_count == 16'd1) begin
                            n_phase = PH_HEADER;
                        end
                    end
                    default: begin
                        n_phase = PH_HEADER;
                    end
                endcase
            end
        end
    end

    // operation produced by the accepted byte
    always_comb begin
        o_token_valid = 1'b0;
        o_token.op    = OP_EMIT;
        o_token.kind  = r_section;
        o_token.value = w_word;
        o_token.last  = 1'b0;
        if (w_accept) begin
            if (r_phase == PH_LABEL) begin
                o_token_valid = 1'b1;
                o_token.kind  = KIND_SYMBOL;
                o_token.value = {8'd0, i_byte.file_byte};
                o_token.last  = (r_count == 16'd1);
            end else if (r_pending) begin
                case (r_phase)
                    PH_ADDRESS: begin
                        o_token_valid = 1'b1;
                        o_token.op    = OP_SET_ADDR;
                    end
                    PH_COUNT: begin
                        if ((r_section == KIND_SYMBOL) && (w_word == 16'd0)) begin
                            o_token_valid = 1'b1;
                            o_token.kind  = KIND_EMPTY;
                            o_token.value = 16'd0;
                            o_token.last  = 1'b1;
                        end
                    end
                    PH_WORDS: begin
                        o_token_valid = 1'b1;
                    end
                    default: begin
                        o_token_valid = 1'b0;
                    end
                endcase
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_pending <= 1'b0;
            r_upper   <= 8'd0;
            r_section <= KIND_CODE;
            r_count   <= 16'd0;
        end else begin
            r_phase   <= n_phase;
            r_pending <= n_pending;
            r_upper   <= n_upper;
            r_section <= n_section;
            r_count   <= n_count;
        end
    end

    // phases that consume a count never hold a zero count
    `ASSERT_SAME(a_label_count, r_phase == PH_LABEL, r_count != 16'd0, "label phase with zero count")
    `ASSERT_SAME(a_words_count, r_phase == PH_WORDS, r_count != 16'd0, "word phase with zero count")

endmodule

`default_nettype wire

// File: src/ofrp_queue.sv
// ----------------------------------------------------------------------------
// ofrp_queue
// Short first-in first-out queue of operations between front and back
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ofrp_queue import ofrp_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push_valid,
    input  wire t_token i_push_token,
    output logic        o_push_ready,
    output logic        o_pop_valid,
    output t_token      o_pop_token,
    input  wire logic   i_pop_ready
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_token             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count,  n_count;
    logic               w_push, w_pop;

    // handshake
    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_token  = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_token;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // fill count tracks pushes and pops
    `ASSERT_NEXT(a_fill_up, w_push && !w_pop, r_count == $past(r_count) + CNT_W'(1), "fill count did not rise")
    `ASSERT_NEXT(a_fill_down, w_pop && !w_push, r_count == $past(r_count) - CNT_W'(1), "fill count did not fall")

endmodule

`default_nettype wire

// File: src/ofrp_back.sv
// ----------------------------------------------------------------------------
// ofrp_back
// Executes queued operations: keeps the running address and drives the
// registered result channel
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ofrp_back import ofrp_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_tok_valid,
    input  wire t_token i_tok,
    output logic        o_tok_ready,
    ofrp_out_if.source  o_rec
);

    logic [15:0] r_addr,  n_addr;
    logic        r_valid, n_valid;
    t_kind       r_kind;
    logic [15:0] r_taddr;
    logic [15:0] r_value;
    logic        r_last;
    logic        w_pop;
    logic        w_emit;

    // take an operation when the output register is free or being emptied
    assign o_tok_ready = !r_valid || o_rec.ready;
    assign w_pop       = i_tok_valid && o_tok_ready;
    assign w_emit      = w_pop && (i_tok.op == OP_EMIT);

    // running address and output valid
    always_comb begin
        n_addr  = r_addr;
        n_valid = r_valid;
        if (o_rec.ready) begin
            n_valid = 1'b0;
        end
        if (w_pop) begin
            if (i_tok.op == OP_SET_ADDR) begin
                n_addr = i_tok.value;
            end else begin
                n_valid = 1'b1;
                if ((i_tok.kind == KIND_CODE) || (i_tok.kind == KIND_DATA)) begin
                    n_addr = r_addr + 16'd1;
                end
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr  <= 16'd0;
            r_valid <= 1'b0;
        end else begin
            r_addr  <= n_addr;
            r_valid <= n_valid;
        end
    end

    // result payload register
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_kind  <= i_tok.kind;
            r_taddr <= r_addr;
            r_value <= i_tok.value;
            r_last  <= i_tok.last;
        end
    end

    assign o_rec.valid          = r_valid;
    assign o_rec.record_kind    = r_kind;
    assign o_rec.target_address = r_taddr;
    assign o_rec.payload_value  = r_value;
    assign o_rec.last_of_label  = r_last;

    // a memory word steps the address by one
    `ASSERT_NEXT(a_addr_step, w_emit && ((i_tok.kind == KIND_CODE) || (i_tok.kind == KIND_DATA)), r_addr == $past(r_addr) + 16'd1, "address did not step after word")

endmodule

`default_nettype wire

// File: src/object_file_record_parser.sv
// ----------------------------------------------------------------------------
// object_file_record_parser
// Path: a result is registered in the queue and then in the output register after its last byte.
// Throughput: one file byte per cycle while the queue has room, at most one result per cycle.
// Reset: synchronous active-low; parser awaits a header, queue and output empty.
// ----------------------------------------------------------------------------
`default_nettype none

module object_file_record_parser import ofrp_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ofrp_in_if.sink     i_byte,
    ofrp_out_if.source  o_rec
);

    t_token w_front_tok;
    logic   w_front_valid;
    logic   w_front_ready;
    t_token w_back_tok;
    logic   w_back_valid;
    logic   w_back_ready;

    // byte pairing and record phase tracking
    ofrp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_byte        (i_byte),
        .o_token       (w_front_tok),
        .o_token_valid (w_front_valid),
        .i_token_ready (w_front_ready)
    );

    // operation queue
    ofrp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_front_valid),
        .i_push_token (w_front_tok),
        .o_push_ready (w_front_ready),
        .o_pop_valid  (w_back_valid),
        .o_pop_token  (w_back_tok),
        .i_pop_ready  (w_back_ready)
    );

    // address tracking and result output
    ofrp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (w_back_valid),
        .i_tok       (w_back_tok),
        .o_tok_ready (w_back_ready),
        .o_rec       (o_rec)
    );

endmodule

`default_nettype wire

// File: test/object_file_record_parser_tb.sv
// ----------------------------------------------------------------------------
// object_file_record_parser_tb
// Self-checking bench for the object file record parser. A behavioural
// predictor follows the byte stream as it is accepted and queues the
// records the parser must produce. Each record leaving the block is checked
// field by field against the oldest queued one. Stimulus is a short
// directed file, then random records, noise and bad headers under three
// idling mixes. One long hold-off on the output fills the block and stalls
// its input.
// ----------------------------------------------------------------------------
import ofrp_pkg::*;

// one expected record
typedef struct packed {
    t_kind       kind;
    logic [15:0] address;
    logic [15:0] value;
    logic        last;
} t_parsed_record;

// parser behaviour and the queue of records still owed by the block
class record_tracker;
    t_phase         phase;
    logic           byte_pending;
    logic [7:0]     upper_byte;
    t_kind          section_kind;
    logic [15:0]    current_address;
    logic [15:0]    remaining_count;
    t_parsed_record owed_records[$];
    int             fault_count;

    function new();
        phase           = PH_HEADER;
        byte_pending    = 1'b0;
        upper_byte      = 8'h00;
        section_kind    = KIND_CODE;
        current_address = 16'h0000;
        remaining_count = 16'h0000;
        fault_count     = 0;
    endfunction

    function void owe(t_kind kind, logic [15:0] address, logic [15:0] value, logic last);
        t_parsed_record rec;
        rec.kind    = kind;
        rec.address = address;
        rec.value   = value;
        rec.last    = last;
        owed_records.push_back(rec);
    endfunction

    // advance the parser by one accepted file byte
    function void note_byte(logic [7:0] file_byte);
        logic [15:0] assembled;
        // label characters are taken one byte at a time
        if (phase == PH_LABEL) begin
            owe(KIND_SYMBOL, current_address, {8'h00, file_byte}, remaining_count == 16'd1);
            remaining_count = remaining_count - 16'd1;
            if (remaining_count == 16'd0) phase = PH_HEADER;
            return;
        end
        // high byte first
        if (!byte_pending) begin
            upper_byte   = file_byte;
            byte_pending = 1'b1;
            return;
        end
        byte_pending = 1'b0;
        assembled    = {upper_byte, file_byte};
        case (phase)
            PH_HEADER: begin
                if (assembled == HDR_CODE) begin
                    section_kind = KIND_CODE;
                    phase        = PH_ADDRESS;
                end else if (assembled == HDR_DATA) begin
                    section_kind = KIND_DATA;
                    phase        = PH_ADDRESS;
                end else if (assembled == HDR_SYMBOL) begin
                    section_kind = KIND_SYMBOL;
                    phase        = PH_ADDRESS;
                end
            end
            PH_ADDRESS: begin
                current_address = assembled;
                phase           = PH_COUNT;
            end
            PH_COUNT: begin
                remaining_count = assembled;
                if (section_kind == KIND_SYMBOL) begin
                    if (assembled == 16'd0) begin
                        owe(KIND_EMPTY, current_address, 16'h0000, 1'b1);
                        phase = PH_HEADER;
                    end else begin
                        phase = PH_LABEL;
                    end
                end else begin
                    phase = (assembled == 16'd0) ? PH_HEADER : PH_WORDS;
                end
            end
            PH_WORDS: begin
                owe(section_kind, current_address, assembled, 1'b0);
                current_address = current_address + 16'd1;
                remaining_count = remaining_count - 16'd1;
                if (remaining_count == 16'd0) phase = PH_HEADER;
            end
            default: phase = PH_HEADER;
        endcase
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            fault_count++;
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
        end
    endfunction

    // check one record leaving the block against the oldest owed one
    function void check_record(logic [1:0] kind, logic [15:0] address,
                               logic [15:0] value, logic last);
        t_parsed_record want;
        if (owed_records.size() == 0) begin
            fault_count++;
            $display("%0t: unexpected record, expected none, got %h %h %h %b",
                     $time, kind, address, value, last);
            return;
        end
        want = owed_records.pop_front();
        compare_field("record_kind", {14'd0, want.kind}, {14'd0, kind});
        compare_field("target_address", want.address, address);
        compare_field("payload_value", want.value, value);
        compare_field("last_of_label", {15'd0, want.last}, {15'd0, last});
    endfunction
endclass

module object_file_record_parser_tb;

    localparam int STALL_LIMIT       = 2000;
    localparam int HOLD_CYCLES       = 400;
    localparam int DRAIN_CYCLES      = 8;
    localparam int BYTES_PER_SETTING = 250;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ofrp_in_if  byte_if ();
    ofrp_out_if rec_if ();

    object_file_record_parser DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_if),
        .o_rec   (rec_if)
    );

    record_tracker tracker = new();

    int   send_idle_pct = 31;
    int   recv_idle_pct = 59;
    int   bytes_sent    = 0;
    logic hold_armed    = 1'b0;

    // clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // output side: random stalls plus one long hold-off
    initial begin
        int hold_left;
        bit hold_done;
        hold_left    = 0;
        hold_done    = 1'b0;
        rec_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left != 0) begin
                rec_if.ready <= 1'b0;
                hold_left--;
            end else if (hold_armed && !hold_done) begin
                rec_if.ready <= 1'b0;
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end else begin
                rec_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // check every record taken from the block
    always @(posedge i_clk) begin
        if (i_rst_n && rec_if.valid && rec_if.ready)
            tracker.check_record(rec_if.record_kind, rec_if.target_address,
                                 rec_if.payload_value, rec_if.last_of_label);
    end

    // watchdog on cycles with no transfer on either side
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((byte_if.valid && byte_if.ready) || (rec_if.valid && rec_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    // drive one input byte, with random gaps, and track it once accepted
    task automatic send_byte(input logic [7:0] value);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            byte_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_if.valid     <= 1'b1;
        byte_if.file_byte <= value;
        @(posedge i_clk);
        while (!byte_if.ready) @(posedge i_clk);
        tracker.note_byte(value);
        bytes_sent++;
    endtask

    // big-endian pair
    task automatic send_word(input logic [15:0] value);
        send_byte(value[15:8]);
        send_byte(value[7:0]);
    endtask

    // feed random bytes until the parser is back at a header boundary
    task automatic realign();
        while (tracker.phase != PH_HEADER || tracker.byte_pending)
            send_byte(8'($urandom));
    endtask

    // well-formed record with random address, size and content
    task automatic send_random_record();
        t_kind       kind;
        logic [15:0] address;
        int          count;
        int          pick;
        pick = $urandom_range(0, 2);
        case (pick)
            0:       kind = KIND_CODE;
            1:       kind = KIND_DATA;
            default: kind = KIND_SYMBOL;
        endcase
        // bias some addresses to the top of memory so that they wrap
        if ($urandom_range(0, 3) == 0)
            address = 16'hFFFF - 16'($urandom_range(0, 7));
        else
            address = 16'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 10)      count = 0;
        else if (pick < 90) count = $urandom_range(1, 8);
        else                count = $urandom_range(9, 40);
        case (kind)
            KIND_CODE: send_word(HDR_CODE);
            KIND_DATA: send_word(HDR_DATA);
            default:   send_word(HDR_SYMBOL);
        endcase
        send_word(address);
        send_word(16'(count));
        repeat (count) begin
            if (kind == KIND_SYMBOL) send_byte(8'($urandom));
            else                     send_word(16'($urandom));
        end
    endtask

    // one random piece of file: mostly records, some bad headers and noise
    task automatic send_random_piece();
        int          pick;
        logic [15:0] bad_header;
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
            send_random_record();
        end else if (pick < 90) begin
            // near misses of the real headers as well as arbitrary values
            case ($urandom_range(0, 3))
                0:       bad_header = HDR_CODE ^ (16'd1 << $urandom_range(0, 15));
                1:       bad_header = HDR_DATA ^ (16'd1 << $urandom_range(0, 15));
                2:       bad_header = HDR_SYMBOL ^ (16'd1 << $urandom_range(0, 15));
                default: bad_header = 16'($urandom);
            endcase
            send_word(bad_header);
        end else begin
            repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
        end
        realign();
    endtask

    // main sequence
    initial begin
        i_rst_n           = 1'b0;
        byte_if.valid     = 1'b0;
        byte_if.file_byte = 8'h00;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // code record across the top of memory, extreme values
        send_word(HDR_CODE);
        send_word(16'hFFFF);
        send_word(16'd2);
        send_word(16'h0000);
        send_word(16'hFFFF);
        // header one bit off code, dropped
        send_word(HDR_CODE ^ 16'h0001);
        // empty label
        send_word(HDR_SYMBOL);
        send_word(16'h8001);
        send_word(16'h0000);
        // two label characters at the byte extremes
        send_word(HDR_SYMBOL);
        send_word(16'h7FFE);
        send_word(16'd2);
        send_byte(8'h00);
        send_byte(8'hFF);
        // empty data record
        send_word(HDR_DATA);
        send_word(16'hA5A5);
        send_word(16'h0000);

        // random part under three idling mixes
        for (int setting = 0; setting < 3; setting++) begin
            int target;
            case (setting)
                0: begin
                    send_idle_pct = 31;
                    recv_idle_pct = 59;
                    hold_armed    = 1'b1;
                end
                1: begin
                    send_idle_pct = 59;
                    recv_idle_pct = 31;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            target = bytes_sent + BYTES_PER_SETTING;
            while (bytes_sent < target) send_random_piece();
        end
        byte_if.valid <= 1'b0;

        // let the block drain, then keep watching for anything stray
        while (tracker.owed_records.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (tracker.owed_records.size() != 0) begin
            $display("%0t: %0d records never arrived", $time, tracker.owed_records.size());
            tracker.fault_count++;
        end
        if (tracker.fault_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
